>>> rtl/core/sesm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sesm_pkg
// Types and codes shared by the safety event state machine core.
// ----------------------------------------------------------------------------
package sesm_pkg;

	// number of fault codes; raised codes must lie below this
	localparam logic [4:0] NUM_FAULT_CODES = 5'd8;

	// event kinds
	localparam logic [3:0] EV_MOVE     = 4'd0;
	localparam logic [3:0] EV_HOLD     = 4'd1;
	localparam logic [3:0] EV_COMPLETE = 4'd2;
	localparam logic [3:0] EV_HEARTBT  = 4'd3;
	localparam logic [3:0] EV_STOP     = 4'd4;
	localparam logic [3:0] EV_WATCHDOG = 4'd5;
	localparam logic [3:0] EV_RAISE    = 4'd6;
	localparam logic [3:0] EV_RESET    = 4'd7;

	// safety states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_STOP  = 2'd2;
	localparam logic [1:0] ST_FAULT = 2'd3;

	// device modes
	localparam logic [2:0] MD_IDLE    = 3'd0;
	localparam logic [2:0] MD_MOVING  = 3'd1;
	localparam logic [2:0] MD_HOLDING = 3'd2;
	localparam logic [2:0] MD_STOPPED = 3'd3;
	localparam logic [2:0] MD_FAULTED = 3'd4;

	// fault codes
	localparam logic [3:0] FC_NONE      = 4'd0;
	localparam logic [3:0] FC_MALFORMED = 4'd1;
	localparam logic [3:0] FC_STOP_REJ  = 4'd2;
	localparam logic [3:0] FC_WATCHDOG  = 4'd3;

	// result codes
	localparam logic RC_ACCEPTED = 1'b0;
	localparam logic RC_REJECTED = 1'b1;

	// reason codes
	localparam logic [2:0] RS_NONE      = 3'd0;
	localparam logic [2:0] RS_BAD_ARG   = 3'd1;
	localparam logic [2:0] RS_BAD_TRANS = 3'd2;
	localparam logic [2:0] RS_UNAUTH    = 3'd3;
	localparam logic [2:0] RS_CAUSE     = 3'd4;
	localparam logic [2:0] RS_STOP_REJ  = 3'd5;
	localparam logic [2:0] RS_BAD_EVENT = 3'd6;

	typedef struct packed {
		logic [3:0] req_type;
		logic [3:0] raised_fault;
		logic       reset_auth;
		logic       cause_clear;
	} req_t;

	typedef struct packed {
		logic       verdict;
		logic [2:0] reason_code;
		logic [1:0] prior_state;
		logic [1:0] new_state;
		logic [2:0] new_mode;
		logic [3:0] latched_fault;
		logic [3:0] response_fault;
		logic       exec_active;
		logic       safe_outputs;
	} rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/sesm_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sesm_req_if
// Event channel: one event item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface sesm_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] req_type;
	logic [3:0] raised_fault;
	logic       reset_auth;
	logic       cause_clear;

	modport source (
		output valid, req_type, raised_fault, reset_auth, cause_clear,
		input  ready
	);

	modport sink (
		input  valid, req_type, raised_fault, reset_auth, cause_clear,
		output ready
	);
endinterface
`default_nettype wire

>>> rtl/core/sesm_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sesm_rsp_if
// Result channel: one result item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface sesm_rsp_if;
	logic       valid;
	logic       ready;
	logic       verdict;
	logic [2:0] reason_code;
	logic [1:0] prior_state;
	logic [1:0] new_state;
	logic [2:0] new_mode;
	logic [3:0] latched_fault;
	logic [3:0] response_fault;
	logic       exec_active;
	logic       safe_outputs;

	modport source (
		output valid, verdict, reason_code, prior_state, new_state, new_mode,
		       latched_fault, response_fault, exec_active, safe_outputs,
		input  ready
	);

	modport sink (
		input  valid, verdict, reason_code, prior_state, new_state, new_mode,
		       latched_fault, response_fault, exec_active, safe_outputs,
		output ready
	);
endinterface
`default_nettype wire

>>> rtl/core/sesm_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sesm_in_stage
// Input register for event items.
// ----------------------------------------------------------------------------
module sesm_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire sesm_pkg::req_t in_data,
	input  wire logic          advance,
	output logic               valid_s1,
	output sesm_pkg::req_t     req_s1
);

	// register frees up when its item moves on in this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/sesm_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sesm_fsm
// Safety state, mode and fault latch, with the per-event decision logic.
// ----------------------------------------------------------------------------
module sesm_fsm (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire sesm_pkg::req_t req_s1,
	output sesm_pkg::rsp_t      rsp_d
);

	logic [1:0] state_q;
	logic [2:0] mode_q;
	logic [3:0] latch_q;
	logic [1:0] state_d;
	logic [2:0] mode_d;
	logic [3:0] latch_d;
	logic       rej;
	logic [2:0] reason;
	logic [3:0] resp_fault;
	logic       keep_latch;
	logic       raise_ok;

	function automatic logic code_active(input logic [3:0] code);
		code_active = (code != sesm_pkg::FC_NONE) &&
		              ({1'b0, code} < sesm_pkg::NUM_FAULT_CODES);
	endfunction

	// first fault wins while already faulted with an active latch
	assign keep_latch = (state_q == sesm_pkg::ST_FAULT) && code_active(latch_q);
	assign raise_ok   = code_active(req_s1.raised_fault) &&
	                    (req_s1.raised_fault != sesm_pkg::FC_STOP_REJ);

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		latch_d    = latch_q;
		rej        = sesm_pkg::RC_ACCEPTED;
		reason     = sesm_pkg::RS_NONE;
		resp_fault = sesm_pkg::FC_NONE;
		unique case (req_s1.req_type)
			sesm_pkg::EV_MOVE, sesm_pkg::EV_HOLD: begin
				if (state_q != sesm_pkg::ST_IDLE) begin
					state_d    = sesm_pkg::ST_FAULT;
					mode_d     = sesm_pkg::MD_FAULTED;
					latch_d    = keep_latch ? latch_q : sesm_pkg::FC_MALFORMED;
					rej        = sesm_pkg::RC_REJECTED;
					reason     = sesm_pkg::RS_BAD_TRANS;
					resp_fault = sesm_pkg::FC_MALFORMED;
				end else begin
					state_d = sesm_pkg::ST_EXEC;
					mode_d  = (req_s1.req_type == sesm_pkg::EV_MOVE) ?
					          sesm_pkg::MD_MOVING : sesm_pkg::MD_HOLDING;
					latch_d = sesm_pkg::FC_NONE;
				end
			end
			sesm_pkg::EV_COMPLETE: begin
				if (state_q != sesm_pkg::ST_EXEC) begin
					rej    = sesm_pkg::RC_REJECTED;
					reason = sesm_pkg::RS_BAD_TRANS;
				end else begin
					state_d = sesm_pkg::ST_IDLE;
					mode_d  = sesm_pkg::MD_IDLE;
					latch_d = sesm_pkg::FC_NONE;
				end
			end
			sesm_pkg::EV_HEARTBT: begin
				if (state_q == sesm_pkg::ST_FAULT) begin
					rej        = sesm_pkg::RC_REJECTED;
					reason     = sesm_pkg::RS_BAD_TRANS;
					resp_fault = latch_q;
				end
			end
			sesm_pkg::EV_STOP: begin
				if (state_q == sesm_pkg::ST_FAULT) begin
					rej        = sesm_pkg::RC_REJECTED;
					reason     = sesm_pkg::RS_STOP_REJ;
					resp_fault = sesm_pkg::FC_STOP_REJ;
				end else begin
					state_d = sesm_pkg::ST_STOP;
					mode_d  = sesm_pkg::MD_STOPPED;
					latch_d = sesm_pkg::FC_NONE;
				end
			end
			sesm_pkg::EV_WATCHDOG: begin
				state_d    = sesm_pkg::ST_FAULT;
				mode_d     = sesm_pkg::MD_FAULTED;
				latch_d    = keep_latch ? latch_q : sesm_pkg::FC_WATCHDOG;
				resp_fault = sesm_pkg::FC_WATCHDOG;
			end
			sesm_pkg::EV_RAISE: begin
				state_d = sesm_pkg::ST_FAULT;
				mode_d  = sesm_pkg::MD_FAULTED;
				if (!raise_ok) begin
					latch_d    = keep_latch ? latch_q : sesm_pkg::FC_MALFORMED;
					rej        = sesm_pkg::RC_REJECTED;
					reason     = sesm_pkg::RS_BAD_ARG;
					resp_fault = sesm_pkg::FC_MALFORMED;
				end else begin
					latch_d    = keep_latch ? latch_q : req_s1.raised_fault;
					resp_fault = req_s1.raised_fault;
				end
			end
			sesm_pkg::EV_RESET: begin
				priority if (!req_s1.reset_auth) begin
					rej    = sesm_pkg::RC_REJECTED;
					reason = sesm_pkg::RS_UNAUTH;
				end else if (!req_s1.cause_clear) begin
					rej    = sesm_pkg::RC_REJECTED;
					reason = sesm_pkg::RS_CAUSE;
				end else if (state_q == sesm_pkg::ST_EXEC) begin
					state_d    = sesm_pkg::ST_FAULT;
					mode_d     = sesm_pkg::MD_FAULTED;
					latch_d    = sesm_pkg::FC_MALFORMED;
					rej        = sesm_pkg::RC_REJECTED;
					reason     = sesm_pkg::RS_BAD_TRANS;
					resp_fault = sesm_pkg::FC_MALFORMED;
				end else begin
					state_d = sesm_pkg::ST_IDLE;
					mode_d  = sesm_pkg::MD_IDLE;
					latch_d = sesm_pkg::FC_NONE;
				end
			end
			default: begin
				// unknown event kind
				state_d    = sesm_pkg::ST_FAULT;
				mode_d     = sesm_pkg::MD_FAULTED;
				latch_d    = keep_latch ? latch_q : sesm_pkg::FC_MALFORMED;
				rej        = sesm_pkg::RC_REJECTED;
				reason     = sesm_pkg::RS_BAD_EVENT;
				resp_fault = sesm_pkg::FC_MALFORMED;
			end
		endcase
	end

	always_comb begin
		rsp_d.verdict        = rej;
		rsp_d.reason_code    = reason;
		rsp_d.prior_state    = state_q;
		rsp_d.new_state      = state_d;
		rsp_d.new_mode       = mode_d;
		rsp_d.latched_fault  = latch_d;
		rsp_d.response_fault = resp_fault;
		rsp_d.exec_active    = (state_d == sesm_pkg::ST_EXEC);
		rsp_d.safe_outputs   = (state_d != sesm_pkg::ST_EXEC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sesm_pkg::ST_IDLE;
			mode_q  <= sesm_pkg::MD_IDLE;
			latch_q <= sesm_pkg::FC_NONE;
		end else if (advance) begin
			state_q <= state_d;
			mode_q  <= mode_d;
			latch_q <= latch_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/sesm_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sesm_out_stage
// Result register; holds a result item until the receiver takes it.
// ----------------------------------------------------------------------------
module sesm_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_s1,
	input  wire sesm_pkg::rsp_t rsp_d,
	input  wire logic           out_ready,
	output logic                out_valid,
	output sesm_pkg::rsp_t      rsp_s2,
	output logic                advance
);

	logic valid_s2;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/safety_event_state_machine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// safety_event_state_machine_core
// Fail-closed safety state machine: one result item for every event item.
// ----------------------------------------------------------------------------
// Events arrive on the req channel and results leave on the rsp channel,
// both valid/ready; an item moves when valid and ready are high at a clock
// edge. Every event gives exactly one result, in order.
// A taken event waits in the input register until the result register is
// free; the decision logic then loads the result register and updates the
// safety state, mode and fault latch, and the result is held there until
// it is taken. Throughput is one event per cycle while results are taken,
// as the next-state logic reads the state registers that it writes.
// While the receiver stalls, the result register holds its item and the
// input register can still take one more event; after that req.ready drops
// until the result is taken.
// arst_n clears both stages and puts the block in idle, mode idle, with no
// fault latched.
// ----------------------------------------------------------------------------
module safety_event_state_machine_core (
	input wire logic   clk,
	input wire logic   arst_n,
	sesm_req_if.sink   req,
	sesm_rsp_if.source rsp
);

	sesm_pkg::req_t in_data;
	sesm_pkg::req_t req_s1;
	sesm_pkg::rsp_t rsp_d;
	sesm_pkg::rsp_t rsp_s2;
	logic           valid_s1;
	logic           advance;

	always_comb begin
		in_data.req_type     = req.req_type;
		in_data.raised_fault = req.raised_fault;
		in_data.reset_auth   = req.reset_auth;
		in_data.cause_clear  = req.cause_clear;
	end

	sesm_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	sesm_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req_s1  (req_s1),
		.rsp_d   (rsp_d)
	);

	sesm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.rsp_d     (rsp_d),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.rsp_s2    (rsp_s2),
		.advance   (advance)
	);

	assign rsp.verdict        = rsp_s2.verdict;
	assign rsp.reason_code    = rsp_s2.reason_code;
	assign rsp.prior_state    = rsp_s2.prior_state;
	assign rsp.new_state      = rsp_s2.new_state;
	assign rsp.new_mode       = rsp_s2.new_mode;
	assign rsp.latched_fault  = rsp_s2.latched_fault;
	assign rsp.response_fault = rsp_s2.response_fault;
	assign rsp.exec_active    = rsp_s2.exec_active;
	assign rsp.safe_outputs   = rsp_s2.safe_outputs;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the safety event state machine core. A scripted sequence
// drives every event kind, each in one or more safety states, then random events
// (mostly legal sequences, some noise) run with random idling on both
// channels and one long result stall. Each result is checked field by field
// against values written in the script or a state machine tracked in the testbench.
// ----------------------------------------------------------------------------
module tb_top;
	import sesm_pkg::*;

	localparam int RAND_ITEMS   = 1425;
	localparam int QUIET_ITEMS  = 200;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 300000;

	localparam logic [3:0] TOP_CODE   = 4'(NUM_FAULT_CODES - 5'd1);
	localparam logic [3:0] EV_UNKNOWN = 4'hF;

	typedef struct {
		req_t ev;
		bit   typed;
		rsp_t want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	sesm_req_if evt_ch ();
	sesm_rsp_if res_ch ();

	safety_event_state_machine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (evt_ch),
		.rsp    (res_ch)
	);

	always #5 clk = ~clk;

	// tracked copy of the machine
	logic [1:0] sm_state = ST_IDLE;
	logic [2:0] sm_mode  = MD_IDLE;
	logic [3:0] sm_latch = FC_NONE;

	rsp_t  due_results[$];
	step_t script[$];
	int    mismatches = 0;
	int    cycles = 0;
	bit    quiet = 1'b0;
	bit    hold_on = 1'b0;

	function automatic void settle(logic [1:0] st, logic [2:0] md);
		sm_state = st;
		sm_mode  = md;
		sm_latch = FC_NONE;
	endfunction

	// the first active fault stays latched
	function automatic void trip_fault(logic [3:0] code);
		if (sm_state != ST_FAULT || sm_latch == FC_NONE || {1'b0, sm_latch} >= NUM_FAULT_CODES)
			sm_latch = code;
		sm_state = ST_FAULT;
		sm_mode  = MD_FAULTED;
	endfunction

	function automatic rsp_t apply_event(req_t ev);
		rsp_t       o;
		logic [1:0] was;
		logic       rej;
		logic [2:0] why;
		logic [3:0] flt;
		was = sm_state;
		rej = RC_ACCEPTED;
		why = RS_NONE;
		flt = FC_NONE;
		case (ev.req_type)
			EV_MOVE, EV_HOLD: begin
				if (sm_state != ST_IDLE) begin
					trip_fault(FC_MALFORMED);
					rej = RC_REJECTED;
					why = RS_BAD_TRANS;
					flt = FC_MALFORMED;
				end else begin
					settle(ST_EXEC, ev.req_type == EV_MOVE ? MD_MOVING : MD_HOLDING);
				end
			end
			EV_COMPLETE: begin
				if (sm_state != ST_EXEC) begin
					rej = RC_REJECTED;
					why = RS_BAD_TRANS;
				end else begin
					settle(ST_IDLE, MD_IDLE);
				end
			end
			EV_HEARTBT: begin
				if (sm_state == ST_FAULT) begin
					rej = RC_REJECTED;
					why = RS_BAD_TRANS;
					flt = sm_latch;
				end
			end
			EV_STOP: begin
				if (sm_state == ST_FAULT) begin
					rej = RC_REJECTED;
					why = RS_STOP_REJ;
					flt = FC_STOP_REJ;
				end else begin
					settle(ST_STOP, MD_STOPPED);
				end
			end
			EV_WATCHDOG: begin
				trip_fault(FC_WATCHDOG);
				flt = FC_WATCHDOG;
			end
			EV_RAISE: begin
				if (ev.raised_fault == FC_NONE || ev.raised_fault == FC_STOP_REJ ||
				    {1'b0, ev.raised_fault} >= NUM_FAULT_CODES) begin
					trip_fault(FC_MALFORMED);
					rej = RC_REJECTED;
					why = RS_BAD_ARG;
					flt = FC_MALFORMED;
				end else begin
					trip_fault(ev.raised_fault);
					flt = ev.raised_fault;
				end
			end
			EV_RESET: begin
				if (!ev.reset_auth) begin
					rej = RC_REJECTED;
					why = RS_UNAUTH;
				end else if (!ev.cause_clear) begin
					rej = RC_REJECTED;
					why = RS_CAUSE;
				end else if (sm_state == ST_EXEC) begin
					trip_fault(FC_MALFORMED);
					rej = RC_REJECTED;
					why = RS_BAD_TRANS;
					flt = FC_MALFORMED;
				end else begin
					settle(ST_IDLE, MD_IDLE);
				end
			end
			default: begin
				trip_fault(FC_MALFORMED);
				rej = RC_REJECTED;
				why = RS_BAD_EVENT;
				flt = FC_MALFORMED;
			end
		endcase
		o.verdict        = rej;
		o.reason_code    = why;
		o.prior_state    = was;
		o.new_state      = sm_state;
		o.new_mode       = sm_mode;
		o.latched_fault  = sm_latch;
		o.response_fault = flt;
		o.exec_active    = (sm_state == ST_EXEC);
		o.safe_outputs   = (sm_state != ST_EXEC);
		return o;
	endfunction

	function automatic req_t mk_event(logic [3:0] kind, logic [3:0] code, logic auth, logic clr);
		req_t r;
		r.req_type     = kind;
		r.raised_fault = code;
		r.reset_auth   = auth;
		r.cause_clear  = clr;
		return r;
	endfunction

	function automatic rsp_t outcome(logic rc, logic [2:0] rs, logic [1:0] ps, logic [1:0] ns,
			logic [2:0] md, logic [3:0] lf, logic [3:0] rf);
		rsp_t o;
		o.verdict        = rc;
		o.reason_code    = rs;
		o.prior_state    = ps;
		o.new_state      = ns;
		o.new_mode       = md;
		o.latched_fault  = lf;
		o.response_fault = rf;
		o.exec_active    = (ns == ST_EXEC);
		o.safe_outputs   = (ns != ST_EXEC);
		return o;
	endfunction

	function automatic void add_step(req_t ev, bit typed = 1'b0, rsp_t want = '0);
		step_t s;
		s.ev    = ev;
		s.typed = typed;
		s.want  = want;
		script.push_back(s);
	endfunction

	// mostly legal sequences steered by the tracked state, some noise
	function automatic req_t pick_event();
		int         roll;
		logic [3:0] kind;
		logic [3:0] code;
		logic       auth;
		logic       clr;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			kind = 4'($urandom_range(EV_RESET + 1, 15));
		else if (sm_state == ST_FAULT && roll < 50)
			kind = EV_RESET;
		else if (sm_state == ST_IDLE && roll < 45)
			kind = 4'($urandom_range(EV_MOVE, EV_HOLD));
		else if (sm_state == ST_EXEC && roll < 40)
			kind = roll[0] ? EV_COMPLETE : EV_HEARTBT;
		else
			kind = 4'($urandom_range(EV_MOVE, EV_RESET));
		if ($urandom_range(0, 3) != 0)
			code = ($urandom_range(0, 3) == 0) ? FC_MALFORMED :
				4'($urandom_range(FC_WATCHDOG, TOP_CODE));
		else
			code = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 4) != 0) begin
			auth = 1'b1;
			clr  = 1'b1;
		end else begin
			auth = 1'($urandom_range(0, 1));
			clr  = 1'($urandom_range(0, 1));
		end
		return mk_event(kind, code, auth, clr);
	endfunction

	// returns at the edge where the item is taken
	task automatic offer(req_t ev);
		evt_ch.valid        <= 1'b1;
		evt_ch.req_type     <= ev.req_type;
		evt_ch.raised_fault <= ev.raised_fault;
		evt_ch.reset_auth   <= ev.reset_auth;
		evt_ch.cause_clear  <= ev.cause_clear;
		@(posedge clk);
		while (!evt_ch.ready)
			@(posedge clk);
	endtask

	task automatic maybe_pause();
		if (!quiet && !hold_on && $urandom_range(0, 7) == 0) begin
			evt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14))
				@(posedge clk);
		end
	endtask

	function automatic void compare_field(string name, logic [3:0] want, logic [3:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		req_t ev;
		rsp_t pred;
		arst_n              <= 1'b0;
		evt_ch.valid        <= 1'b0;
		evt_ch.req_type     <= EV_MOVE;
		evt_ch.raised_fault <= FC_NONE;
		evt_ch.reset_auth   <= 1'b0;
		evt_ch.cause_clear  <= 1'b0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_step(mk_event(EV_HEARTBT, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_ACCEPTED, RS_NONE, ST_IDLE, ST_IDLE, MD_IDLE, FC_NONE, FC_NONE));
		add_step(mk_event(EV_COMPLETE, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_REJECTED, RS_BAD_TRANS, ST_IDLE, ST_IDLE, MD_IDLE, FC_NONE, FC_NONE));
		add_step(mk_event(EV_MOVE, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_ACCEPTED, RS_NONE, ST_IDLE, ST_EXEC, MD_MOVING, FC_NONE, FC_NONE));
		add_step(mk_event(EV_COMPLETE, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_ACCEPTED, RS_NONE, ST_EXEC, ST_IDLE, MD_IDLE, FC_NONE, FC_NONE));
		add_step(mk_event(EV_HOLD, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_ACCEPTED, RS_NONE, ST_IDLE, ST_EXEC, MD_HOLDING, FC_NONE, FC_NONE));
		// begin while executing
		add_step(mk_event(EV_HOLD, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_REJECTED, RS_BAD_TRANS, ST_EXEC, ST_FAULT, MD_FAULTED,
				FC_MALFORMED, FC_MALFORMED));
		add_step(mk_event(EV_HEARTBT, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_REJECTED, RS_BAD_TRANS, ST_FAULT, ST_FAULT, MD_FAULTED,
				FC_MALFORMED, FC_MALFORMED));
		add_step(mk_event(EV_STOP, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_REJECTED, RS_STOP_REJ, ST_FAULT, ST_FAULT, MD_FAULTED,
				FC_MALFORMED, FC_STOP_REJ));
		// watchdog in fault keeps the first fault
		add_step(mk_event(EV_WATCHDOG, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_ACCEPTED, RS_NONE, ST_FAULT, ST_FAULT, MD_FAULTED,
				FC_MALFORMED, FC_WATCHDOG));
		add_step(mk_event(EV_RESET, FC_NONE, 1'b0, 1'b1), 1'b1,
			outcome(RC_REJECTED, RS_UNAUTH, ST_FAULT, ST_FAULT, MD_FAULTED,
				FC_MALFORMED, FC_NONE));
		add_step(mk_event(EV_RESET, FC_NONE, 1'b1, 1'b0), 1'b1,
			outcome(RC_REJECTED, RS_CAUSE, ST_FAULT, ST_FAULT, MD_FAULTED,
				FC_MALFORMED, FC_NONE));
		add_step(mk_event(EV_RESET, FC_NONE, 1'b1, 1'b1), 1'b1,
			outcome(RC_ACCEPTED, RS_NONE, ST_FAULT, ST_IDLE, MD_IDLE, FC_NONE, FC_NONE));
		add_step(mk_event(EV_RAISE, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_REJECTED, RS_BAD_ARG, ST_IDLE, ST_FAULT, MD_FAULTED,
				FC_MALFORMED, FC_MALFORMED));
		add_step(mk_event(EV_RESET, FC_NONE, 1'b1, 1'b1));
		add_step(mk_event(EV_RAISE, FC_STOP_REJ, 1'b0, 1'b0));
		add_step(mk_event(EV_RAISE, 4'hF, 1'b1, 1'b1));
		add_step(mk_event(EV_RESET, 4'hF, 1'b1, 1'b1));
		add_step(mk_event(EV_RAISE, TOP_CODE, 1'b0, 1'b0), 1'b1,
			outcome(RC_ACCEPTED, RS_NONE, ST_IDLE, ST_FAULT, MD_FAULTED, TOP_CODE, TOP_CODE));
		add_step(mk_event(EV_RESET, FC_NONE, 1'b1, 1'b1));
		add_step(mk_event(EV_STOP, FC_NONE, 1'b0, 1'b0));
		add_step(mk_event(EV_MOVE, FC_NONE, 1'b0, 1'b0));
		add_step(mk_event(EV_RESET, FC_NONE, 1'b1, 1'b1));
		add_step(mk_event(EV_MOVE, FC_NONE, 1'b0, 1'b0));
		// cleared reset while executing
		add_step(mk_event(EV_RESET, FC_NONE, 1'b1, 1'b1), 1'b1,
			outcome(RC_REJECTED, RS_BAD_TRANS, ST_EXEC, ST_FAULT, MD_FAULTED,
				FC_MALFORMED, FC_MALFORMED));
		add_step(mk_event(EV_UNKNOWN, FC_NONE, 1'b0, 1'b0), 1'b1,
			outcome(RC_REJECTED, RS_BAD_EVENT, ST_FAULT, ST_FAULT, MD_FAULTED,
				FC_MALFORMED, FC_MALFORMED));

		foreach (script[i]) begin
			maybe_pause();
			offer(script[i].ev);
			pred = apply_event(script[i].ev);
			due_results.push_back(script[i].typed ? script[i].want : pred);
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == HOLD_AT)
				hold_on = 1'b1;
			if (n == RAND_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			maybe_pause();
			ev = pick_event();
			offer(ev);
			due_results.push_back(apply_event(ev));
		end
		evt_ch.valid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_on) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_on = 1'b0;
				res_ch.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14))
					@(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_results.size() == 0) begin
				$error("result item arrived with nothing expected");
				mismatches++;
			end else begin
				want = due_results.pop_front();
				compare_field("verdict", 4'(want.verdict), 4'(res_ch.verdict));
				compare_field("reason_code", 4'(want.reason_code), 4'(res_ch.reason_code));
				compare_field("prior_state", 4'(want.prior_state), 4'(res_ch.prior_state));
				compare_field("new_state", 4'(want.new_state), 4'(res_ch.new_state));
				compare_field("new_mode", 4'(want.new_mode), 4'(res_ch.new_mode));
				compare_field("latched_fault", want.latched_fault, res_ch.latched_fault);
				compare_field("response_fault", want.response_fault, res_ch.response_fault);
				compare_field("exec_active", 4'(want.exec_active),
					4'(res_ch.exec_active));
				compare_field("safe_outputs", 4'(want.safe_outputs),
					4'(res_ch.safe_outputs));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
